>>> sv/shc_pkg.sv
package shc_pkg;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  reg_select;
		logic [31:0] write_data;
		logic [31:0] miso_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        rx_irq;
		logic        tx_irq;
		logic        fault_irq;
		logic        sdo_pin;
		logic        bus_valid;
		logic [31:0] bus_word;
	} out_item_t;

	// Access modes of an input beat.
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Classified operations passed from the front to the back.
	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_STATUS = 3'd1;
	localparam logic [2:0] REG_BUF    = 3'd2;
	localparam logic [2:0] REG_BAUD   = 3'd3;
	localparam logic [2:0] REG_CTRL2  = 3'd4;

	localparam logic [1:0] KIND_BUS    = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_TIMED  = 2'd2;

	localparam logic [31:0] CTRL2_RESET = 32'd3072;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  sel;
		logic [31:0] wdata;
		logic [31:0] miso;
	} cmd_t;

endpackage

>>> sv/spi_host_controller_fifo.sv
// Channel  Direction  Handshake              Beat
// in       input      in_valid / in_stall    in_data (in_item_t)
// out      output     out_valid / out_stall  out_data (out_item_t)
// cfg      input      cfg_we                 cfg_wdata (controller kind)
//
// Every input beat yields exactly one output beat; one beat per cycle is sustained while
// out_stall is low. A beat lands in the two-entry command queue, then the back end
// executes it into the output register. The FIFO head words are prefetched from their
// memories each cycle, so no access waits on a memory port.
// arst_n clears all control state; FIFO memories are not cleared and need no sweep.
// out_stall holds the output register and then fills the queue before in_stall rises.
module spi_host_controller_fifo import shc_pkg::*; #(
	parameter int FIFO_BITS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	shc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	shc_back #(.FIFO_BITS(FIFO_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> sv/shc_front.sv
module shc_front import shc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_pop
);

	cmd_t       ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       push;

	always_comb begin
		cls.op    = OP_NOP;
		cls.sel   = in_data.reg_select;
		cls.wdata = in_data.write_data;
		cls.miso  = in_data.miso_word;
		unique case (in_data.mode)
			MODE_READ:  if (in_data.reg_select <= REG_CTRL2) cls.op = OP_READ;
			MODE_WRITE: if (in_data.reg_select <= REG_CTRL2) cls.op = OP_WRITE;
			MODE_TICK:  cls.op = OP_TICK;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (cmd_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not advance");

endmodule

>>> sv/shc_back.sv
module shc_back import shc_pkg::*; #(
	parameter int FIFO_BITS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int SLOTS = FIFO_BITS / 8;
	localparam int PW    = $clog2(SLOTS);
	localparam int FW    = $clog2(SLOTS + 1);
	localparam logic [FW-1:0] D8   = FW'(FIFO_BITS / 8);
	localparam logic [FW-1:0] D16  = FW'(FIFO_BITS / 16);
	localparam logic [FW-1:0] D32  = FW'(FIFO_BITS / 32);
	localparam logic [FW-1:0] H8   = FW'(FIFO_BITS / 16);
	localparam logic [FW-1:0] H16  = FW'(FIFO_BITS / 32);
	localparam logic [FW-1:0] H32  = FW'(FIFO_BITS / 64);
	localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

	logic [1:0]    kind_q;
	logic [31:0]   ctrl_q, ctrl2_q;
	logic [12:0]   baud_q;
	logic          ovr_q;
	logic [FW-1:0] rx_fill_q, tx_fill_q;
	logic [PW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q;
	logic [31:0]   shift_q;
	logic [5:0]    bits_q;
	logic          armed_q;
	logic [19:0]   ticks_q;
	logic          sdo_q;
	logic [31:0]   rx_mem [SLOTS];
	logic [31:0]   tx_mem [SLOTS];
	logic [31:0]   rx_rd_q, tx_rd_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [31:0]   n_ctrl, n_ctrl2, n_shift;
	logic [12:0]   n_baud;
	logic          n_ovr, n_armed, n_sdo;
	logic [FW-1:0] n_rx_fill, n_tx_fill;
	logic [PW-1:0] n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
	logic [5:0]    n_bits;
	logic [19:0]   n_ticks, t_dec;
	logic          fire, rx_push, rx_pop, tx_push, tx_pop, clr, exch, do_start, pulse;
	logic [31:0]   rd, exch_val, rx_wdata, head_word, status;
	logic [1:0]    kind;
	logic [5:0]    wbits;
	logic [31:0]   wmask;
	logic [FW-1:0] depth, n_depth, n_half;
	logic [14:0]   period;
	logic          n_on, rx_lvl;
	out_item_t     res;

	assign kind   = (kind_q == 2'd3) ? KIND_BUS : kind_q;
	assign wbits  = ctrl_q[11] ? 6'd32 : (ctrl_q[10] ? 6'd16 : 6'd8);
	assign wmask  = ctrl_q[11] ? 32'hFFFF_FFFF : (ctrl_q[10] ? 32'h0000_FFFF : 32'h0000_00FF);
	assign depth  = ctrl_q[11] ? D32 : (ctrl_q[10] ? D16 : D8);
	assign period = {1'b0, baud_q, 1'b0} + 15'd2;

	assign fire    = cmd_valid && (!out_valid_q || !out_stall);
	assign cmd_pop = fire;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		inc = (p == LAST) ? '0 : p + PW'(1);
	endfunction

	// Status word is built from the state before the beat.
	always_comb begin
		status = 32'd0;
		status[6] = ovr_q;
		if (kind != KIND_BUS) begin
			status[3] = (tx_fill_q == '0);
			status[1] = (tx_fill_q >= depth);
			if ((bits_q != 6'd0) || armed_q) status[11] = 1'b1;
			else if (ctrl_q[16]) status[7] = 1'b1;
			if (ctrl_q[16]) status[20:16] = tx_fill_q[4:0];
			if (kind == KIND_SERIAL && ctrl_q[16]) status[5] = 1'b1;
		end else begin
			status[3] = 1'b1;
		end
		if (kind != KIND_SERIAL) begin
			if (ctrl_q[16]) begin
				if (kind == KIND_BUS) status[7] = 1'b1;
				status[0] = (rx_fill_q >= depth);
				status[5] = (rx_fill_q == '0);
				status[28:24] = rx_fill_q[4:0];
			end else if (rx_fill_q != '0) begin
				status[0] = 1'b1;
			end
		end
	end

	always_comb begin
		n_ctrl = ctrl_q;      n_ctrl2 = ctrl2_q;    n_baud = baud_q;
		n_ovr = ovr_q;        n_shift = shift_q;    n_bits = bits_q;
		n_armed = armed_q;    n_ticks = ticks_q;    n_sdo = sdo_q;
		n_rx_fill = rx_fill_q; n_tx_fill = tx_fill_q;
		rd = 32'd0; pulse = 1'b0; exch = 1'b0; exch_val = 32'd0;
		rx_push = 1'b0; rx_pop = 1'b0; tx_push = 1'b0; tx_pop = 1'b0;
		clr = 1'b0; do_start = 1'b0; rx_wdata = 32'd0; head_word = tx_rd_q;
		t_dec = (ticks_q != 20'd0) ? ticks_q - 20'd1 : 20'd0;
		if (fire) begin
			unique case (cmd.op)
				OP_READ: begin
					unique case (cmd.sel)
						REG_CTRL:   rd = ctrl_q;
						REG_STATUS: rd = status;
						REG_BUF: begin
							if (rx_fill_q != '0) begin
								rd = rx_rd_q;
								rx_pop = 1'b1;
								n_rx_fill = rx_fill_q - FW'(1);
							end
						end
						REG_BAUD:   rd = {19'd0, baud_q};
						REG_CTRL2:  rd = ctrl2_q;
						default:    rd = 32'd0;
					endcase
				end
				OP_WRITE: begin
					unique case (cmd.sel)
						REG_CTRL: begin
							n_ctrl = cmd.wdata;
							if (!cmd.wdata[15]) begin
								clr = 1'b1;
								n_armed = 1'b0; n_ticks = 20'd0; n_bits = 6'd0;
								n_shift = 32'd0; n_tx_fill = '0; n_rx_fill = '0;
								n_ovr = 1'b0;
							end
						end
						REG_STATUS: n_ovr = cmd.wdata[6];
						REG_BUF: begin
							if (ctrl_q[15]) begin
								if (kind == KIND_BUS) begin
									exch = 1'b1;
									exch_val = cmd.wdata;
								end else if (tx_fill_q < depth) begin
									tx_push = 1'b1;
									n_tx_fill = tx_fill_q + FW'(1);
									do_start = (bits_q == 6'd0) && !armed_q;
								end
							end
						end
						REG_BAUD:  n_baud = cmd.wdata[12:0];
						REG_CTRL2: n_ctrl2 = cmd.wdata;
						default:   n_baud = baud_q;
					endcase
				end
				OP_TICK: begin
					if (armed_q) begin
						n_ticks = t_dec;
						if (t_dec == 20'd0) begin
							n_armed = 1'b0;
							if (kind == KIND_TIMED) begin
								n_bits = 6'd0;
								exch = 1'b1;
								exch_val = shift_q;
								pulse = 1'b1;
								do_start = 1'b1;
							end else if (bits_q != 6'd0) begin
								n_bits = (bits_q - 6'd1) & 6'd31;
								n_sdo = shift_q[n_bits[4:0]];
								n_armed = 1'b1;
								n_ticks = {5'd0, period};
							end else begin
								pulse = 1'b1;
								do_start = 1'b1;
							end
						end
					end
				end
				default: n_baud = baud_q;
			endcase
		end
		if (exch) begin
			if (rx_fill_q >= depth) begin
				n_ovr = 1'b1;
			end else begin
				rx_push = 1'b1;
				rx_wdata = cmd.miso & wmask;
				n_rx_fill = rx_fill_q + FW'(1);
			end
		end
		if (do_start && n_tx_fill != '0) begin
			// An empty queue before this beat means the head is the word just written.
			head_word = (tx_fill_q == '0) ? cmd.wdata : tx_rd_q;
			tx_pop = 1'b1;
			n_tx_fill = n_tx_fill - FW'(1);
			n_shift = head_word;
			n_armed = 1'b1;
			if (kind == KIND_TIMED) begin
				n_bits = wbits;
				n_ticks = {5'd0, period} << (ctrl_q[11] ? 5 : (ctrl_q[10] ? 4 : 3));
			end else begin
				n_bits = wbits - 6'd1;
				n_sdo = head_word[n_bits[4:0]];
				n_ticks = {5'd0, period};
			end
		end
		n_rx_head = clr ? '0 : (rx_pop ? inc(rx_head_q) : rx_head_q);
		n_rx_tail = clr ? '0 : (rx_push ? inc(rx_tail_q) : rx_tail_q);
		n_tx_head = clr ? '0 : (tx_pop ? inc(tx_head_q) : tx_head_q);
		n_tx_tail = clr ? '0 : (tx_push ? inc(tx_tail_q) : tx_tail_q);
	end

	always_comb begin
		n_on    = n_ctrl[15];
		n_depth = n_ctrl[11] ? D32 : (n_ctrl[10] ? D16 : D8);
		n_half  = n_ctrl[11] ? H32 : (n_ctrl[10] ? H16 : H8);
		unique case (n_ctrl[1:0])
			2'd2:    rx_lvl = (n_rx_fill >= n_half);
			2'd3:    rx_lvl = (n_rx_fill >= n_depth);
			default: rx_lvl = (n_rx_fill != '0);
		endcase
		res.read_data = rd;
		res.rx_irq    = n_on && rx_lvl;
		res.tx_irq    = (kind == KIND_BUS) ? n_on : pulse;
		res.fault_irq = n_on && n_ctrl2[11] && n_ovr;
		res.sdo_pin   = n_sdo;
		res.bus_valid = exch;
		res.bus_word  = exch ? (exch_val & wmask) : 32'd0;
	end

	// The head word is prefetched each cycle; a write to the next head bypasses.
	always_ff @(posedge clk) begin
		if (rx_push) rx_mem[rx_tail_q] <= rx_wdata;
		if (tx_push) tx_mem[tx_tail_q] <= cmd.wdata;
		rx_rd_q <= (rx_push && rx_tail_q == n_rx_head) ? rx_wdata : rx_mem[n_rx_head];
		tx_rd_q <= (tx_push && tx_tail_q == n_tx_head) ? cmd.wdata : tx_mem[n_tx_head];
		if (fire) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_BUS;    ctrl_q <= 32'd0;   ctrl2_q <= CTRL2_RESET;
			baud_q <= 13'd0;       ovr_q <= 1'b0;
			rx_fill_q <= '0;       tx_fill_q <= '0;
			rx_head_q <= '0;       rx_tail_q <= '0;
			tx_head_q <= '0;       tx_tail_q <= '0;
			shift_q <= 32'd0;      bits_q <= 6'd0;    armed_q <= 1'b0;
			ticks_q <= 20'd0;      sdo_q <= 1'b0;     out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) kind_q <= cfg_wdata;
			ctrl_q <= n_ctrl;      ctrl2_q <= n_ctrl2; baud_q <= n_baud;
			ovr_q <= n_ovr;
			rx_fill_q <= n_rx_fill; tx_fill_q <= n_tx_fill;
			rx_head_q <= n_rx_head; rx_tail_q <= n_rx_tail;
			tx_head_q <= n_tx_head; tx_tail_q <= n_tx_tail;
			shift_q <= n_shift;    bits_q <= n_bits;  armed_q <= n_armed;
			ticks_q <= n_ticks;    sdo_q <= n_sdo;
			if (fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_off_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl_q[15] |-> (rx_fill_q == '0 && tx_fill_q == '0 && !armed_q))
		else $error("queues or timer active while disabled");
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill_q != '0 |-> armed_q) else $error("transmit words waiting with idle shifter");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fill_q <= FW'(SLOTS)) && (tx_fill_q <= FW'(SLOTS)))
		else $error("fill count beyond storage");
	a_pulse_kind: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.bus_valid |-> (kind == KIND_BUS || kind == KIND_TIMED))
		else $error("bus exchange in serial kind");

endmodule

>>> tb/spi_host_controller_fifo_tb.sv
module spi_host_controller_fifo_tb;
	import shc_pkg::*;

	localparam int FIFO_BITS = 128;
	localparam int SLOTS = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;

	int errors = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int quiet_cycles = 0;

	// Shadow state of the controller.
	logic [1:0] kind;
	logic [31:0] ctrl, ctrl2, baud;
	logic overrun;
	logic [31:0] rx_mem[SLOTS];
	logic [31:0] tx_mem[SLOTS];
	int rx_cnt, tx_cnt;
	logic [31:0] shreg;
	int bits_pending;
	logic armed;
	int ticks;
	logic sdo;
	logic tx_pulse, bus_v;
	logic [31:0] bus_w;

	out_item_t expected_beats[$];

	spi_host_controller_fifo #(.FIFO_BITS(FIFO_BITS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [1:0] eff_kind();
		return (kind == 2'd3) ? KIND_BUS : kind;
	endfunction

	function automatic int word_bits();
		if (ctrl[11]) return 32;
		return ctrl[10] ? 16 : 8;
	endfunction

	function automatic int fifo_depth();
		return FIFO_BITS / word_bits();
	endfunction

	function automatic logic [31:0] word_mask();
		return (word_bits() == 32) ? 32'hFFFF_FFFF : ((32'd1 << word_bits()) - 32'd1);
	endfunction

	function automatic int period_ticks();
		return 2 * (int'(baud[12:0]) + 1);
	endfunction

	task automatic model_reset();
		kind = KIND_BUS; ctrl = '0; ctrl2 = CTRL2_RESET; baud = '0; overrun = 1'b0;
		rx_cnt = 0; tx_cnt = 0; shreg = '0; bits_pending = 0; armed = 1'b0;
		ticks = 0; sdo = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			rx_mem[i] = '0;
			tx_mem[i] = '0;
		end
	endtask

	function automatic void swap_word(input logic [31:0] value, input logic [31:0] miso);
		bus_v = 1'b1;
		bus_w = value & word_mask();
		if (rx_cnt >= fifo_depth()) begin
			overrun = 1'b1;
		end else if (rx_cnt < SLOTS) begin
			rx_mem[rx_cnt] = miso & word_mask();
			rx_cnt++;
		end
	endfunction

	function automatic void load_shifter();
		if (tx_cnt == 0) return;
		shreg = tx_mem[0];
		tx_cnt--;
		for (int i = 0; i < tx_cnt && i + 1 < SLOTS; i++) tx_mem[i] = tx_mem[i + 1];
		armed = 1'b1;
		if (eff_kind() == KIND_TIMED) begin
			bits_pending = word_bits();
			ticks = word_bits() * period_ticks();
		end else begin
			bits_pending = word_bits() - 1;
			sdo = shreg[bits_pending];
			ticks = period_ticks();
		end
	endfunction

	function automatic void period_end(input logic [31:0] miso);
		if (eff_kind() == KIND_TIMED) begin
			bits_pending = 0;
			swap_word(shreg, miso);
			tx_pulse = 1'b1;
			load_shifter();
		end else if (bits_pending != 0) begin
			bits_pending = (bits_pending - 1) & 31;
			sdo = shreg[bits_pending];
			armed = 1'b1;
			ticks = period_ticks();
		end else begin
			tx_pulse = 1'b1;
			load_shifter();
		end
	endfunction

	function automatic logic [31:0] status_word();
		logic [31:0] st;
		logic [1:0] k;
		int d;
		k = eff_kind();
		d = fifo_depth();
		st = overrun ? 32'h40 : 32'h0;
		if (k != KIND_BUS) begin
			if (tx_cnt == 0) st[3] = 1'b1;
			if (tx_cnt >= d) st[1] = 1'b1;
			if (bits_pending != 0 || armed) st[11] = 1'b1;
			else if (ctrl[16]) st[7] = 1'b1;
			if (ctrl[16]) st[20:16] = tx_cnt[4:0];
			if (k == KIND_SERIAL) begin
				if (ctrl[16]) st[5] = 1'b1;
				return st;
			end
		end else begin
			st[3] = 1'b1;
		end
		if (ctrl[16]) begin
			if (k == KIND_BUS) st[7] = 1'b1;
			if (rx_cnt >= d) st[0] = 1'b1;
			if (rx_cnt == 0) st[5] = 1'b1;
			st[28:24] = rx_cnt[4:0];
		end else if (rx_cnt != 0) begin
			st[0] = 1'b1;
		end
		return st;
	endfunction

	function automatic logic rx_level();
		case (ctrl[1:0])
			2'd2: return rx_cnt >= fifo_depth() / 2;
			2'd3: return rx_cnt >= fifo_depth();
			default: return rx_cnt != 0;
		endcase
	endfunction

	function automatic out_item_t predict_spi_beat(input in_item_t it);
		out_item_t r;
		logic [31:0] rd;
		rd = '0;
		tx_pulse = 1'b0; bus_v = 1'b0; bus_w = '0;
		if (it.mode == MODE_READ) begin
			case (it.reg_select)
				REG_CTRL: rd = ctrl;
				REG_STATUS: rd = status_word();
				REG_BUF: begin
					if (rx_cnt != 0) begin
						rd = rx_mem[0];
						rx_cnt--;
						for (int i = 0; i < rx_cnt && i + 1 < SLOTS; i++)
							rx_mem[i] = rx_mem[i + 1];
					end
				end
				REG_BAUD: rd = baud;
				REG_CTRL2: rd = ctrl2;
				default: ;
			endcase
		end else if (it.mode == MODE_WRITE) begin
			case (it.reg_select)
				REG_CTRL: begin
					ctrl = it.write_data;
					if (!ctrl[15]) begin
						armed = 1'b0; ticks = 0; bits_pending = 0; shreg = '0;
						tx_cnt = 0; rx_cnt = 0; overrun = 1'b0;
					end
				end
				REG_STATUS: overrun = it.write_data[6];
				REG_BUF: begin
					if (ctrl[15]) begin
						if (eff_kind() == KIND_BUS) begin
							swap_word(it.write_data, it.miso_word);
						end else if (tx_cnt < fifo_depth() && tx_cnt < SLOTS) begin
							tx_mem[tx_cnt] = it.write_data;
							tx_cnt++;
							if (bits_pending == 0 && !armed) load_shifter();
						end
					end
				end
				REG_BAUD: baud = it.write_data & 32'h1FFF;
				REG_CTRL2: ctrl2 = it.write_data;
				default: ;
			endcase
		end else if (it.mode == MODE_TICK) begin
			if (armed) begin
				if (ticks > 0) ticks--;
				if (ticks == 0) begin
					armed = 1'b0;
					period_end(it.miso_word);
				end
			end
		end
		r.read_data = rd;
		r.rx_irq = ctrl[15] & rx_level();
		r.tx_irq = (eff_kind() == KIND_BUS) ? ctrl[15] : tx_pulse;
		r.fault_irq = ctrl[15] & ctrl2[11] & overrun;
		r.sdo_pin = sdo;
		r.bus_valid = bus_v;
		r.bus_word = bus_w;
		return r;
	endfunction

	// Leaves in_valid high after the accepting edge; the next call or drain() decides it.
	task automatic send_beat(input logic [1:0] m, input logic [2:0] sel,
			input logic [31:0] wd, input logic [31:0] miso);
		in_item_t it;
		it.mode = m; it.reg_select = sel; it.write_data = wd; it.miso_word = miso;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_beats.push_back(predict_spi_beat(it));
	endtask

	task automatic write_reg(input logic [2:0] sel, input logic [31:0] wd);
		send_beat(MODE_WRITE, sel, wd, $urandom());
	endtask

	task automatic tick_n(input int n);
		for (int i = 0; i < n; i++)
			send_beat(MODE_TICK, 3'($urandom_range(7)), $urandom(), $urandom());
	endtask

	// Waits for the queue of expected beats to drain, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_kind(input logic [1:0] k);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		kind = k;
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, out_data);
				errors++;
			end else begin
				out_item_t e;
				e = expected_beats.pop_front();
				if (e.read_data !== out_data.read_data)
					$display("%0t: read_data expected %h actual %h", $time, e.read_data,
						out_data.read_data);
				if (e.rx_irq !== out_data.rx_irq)
					$display("%0t: rx_irq expected %b actual %b", $time, e.rx_irq, out_data.rx_irq);
				if (e.tx_irq !== out_data.tx_irq)
					$display("%0t: tx_irq expected %b actual %b", $time, e.tx_irq, out_data.tx_irq);
				if (e.fault_irq !== out_data.fault_irq)
					$display("%0t: fault_irq expected %b actual %b", $time, e.fault_irq,
						out_data.fault_irq);
				if (e.sdo_pin !== out_data.sdo_pin)
					$display("%0t: sdo_pin expected %b actual %b", $time, e.sdo_pin,
						out_data.sdo_pin);
				if (e.bus_valid !== out_data.bus_valid)
					$display("%0t: bus_valid expected %b actual %b", $time, e.bus_valid,
						out_data.bus_valid);
				if (e.bus_word !== out_data.bus_word)
					$display("%0t: bus_word expected %h actual %h", $time, e.bus_word,
						out_data.bus_word);
				if (e !== out_data) errors++;
			end
		end
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Ends the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** spi_host_controller_fifo: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] rand_ctrl();
		logic [31:0] c;
		c = $urandom();
		c[15] = ($urandom_range(15) != 0);
		return c;
	endfunction

	task automatic test_registers();
		write_reg(REG_CTRL2, 32'hFFFF_FFFF);
		send_beat(MODE_READ, REG_CTRL2, '0, '0);
		write_reg(REG_CTRL2, 32'h0000_0000);
		send_beat(MODE_READ, REG_CTRL2, '0, '0);
		write_reg(REG_CTRL2, CTRL2_RESET);
		write_reg(REG_BAUD, 32'hFFFF_FFFF);
		send_beat(MODE_READ, REG_BAUD, '0, '0);
		write_reg(REG_BAUD, 32'd0);
		write_reg(REG_STATUS, 32'hFFFF_FFFF);
		send_beat(MODE_READ, REG_STATUS, '0, '0);
		for (int s = 5; s < 8; s++) begin
			write_reg(3'(s), 32'hFFFF_FFFF);
			send_beat(MODE_READ, 3'(s), '0, '0);
		end
		send_beat(2'd3, REG_CTRL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// A buffer write while disabled must be dropped.
		write_reg(REG_CTRL, 32'h0);
		write_reg(REG_BUF, 32'hA5A5_A5A5);
		send_beat(MODE_READ, REG_STATUS, '0, '0);
	endtask

	// Fills the receive FIFO past its depth in bus path mode, reads six words back, then clears it.
	task automatic test_bus_overrun();
		write_reg(REG_CTRL, 32'h0001_8003);
		for (int i = 0; i < 18; i++) send_beat(MODE_WRITE, REG_BUF, $urandom(), $urandom());
		send_beat(MODE_READ, REG_STATUS, '0, '0);
		write_reg(REG_CTRL, 32'h0001_8802);
		for (int i = 0; i < 6; i++) send_beat(MODE_READ, REG_BUF, '0, '0);
		write_reg(REG_CTRL, 32'h0000_0000);
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(99);
			if (r < 4) write_reg(REG_CTRL, rand_ctrl());
			else if (r < 6) write_reg(REG_BAUD, $urandom_range(3) == 0 ? $urandom() :
				$urandom_range(2));
			else if (r < 7) write_reg(REG_STATUS, $urandom());
			else if (r < 8) write_reg(REG_CTRL2, $urandom());
			else if (r < 30) write_reg(REG_BUF, $urandom());
			else if (r < 45) send_beat(MODE_READ, REG_BUF, $urandom(), $urandom());
			else if (r < 52) send_beat(MODE_READ, 3'($urandom_range(7)), $urandom(), $urandom());
			else if (r < 53) send_beat(2'd3, 3'($urandom_range(7)), $urandom(), $urandom());
			else tick_n(1);
		end
	endtask

	task automatic test_kind(input logic [1:0] k, input int n);
		set_kind(k);
		write_reg(REG_CTRL, rand_ctrl() | 32'h8000);
		write_reg(REG_BAUD, $urandom_range(1));
		random_phase(n);
	endtask

	// Changes kind while a timed word is on the wire.
	task automatic test_kind_switch();
		set_kind(KIND_TIMED);
		write_reg(REG_CTRL, 32'h0000_8000);
		write_reg(REG_BAUD, 32'd0);
		write_reg(REG_BUF, 32'h0000_00C3);
		write_reg(REG_BUF, 32'h0000_005A);
		tick_n(3);
		set_kind(KIND_SERIAL);
		tick_n(40);
		set_kind(KIND_TIMED);
		tick_n(40);
	endtask

	initial begin
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 9; receiver_idle_pct = 57;
		test_registers();
		test_bus_overrun();
		test_kind_switch();
		test_kind(KIND_BUS, 150);
		test_kind(KIND_SERIAL, 200);
		sender_idle_pct = 57; receiver_idle_pct = 9;
		test_kind(KIND_TIMED, 200);
		test_kind(2'd3, 150);
		test_kind(KIND_SERIAL, 200);
		sender_idle_pct = 0; receiver_idle_pct = 0;
		test_kind(KIND_TIMED, 250);
		test_kind(KIND_BUS, 150);
		test_kind(KIND_SERIAL, 150);
		drain();
		if (errors == 0)
			$display("** spi_host_controller_fifo: PASSED **");
		else
			$display("** spi_host_controller_fifo: FAILED **");
		$finish;
	end

endmodule
